/* sv/pls_pkg.sv */
package pls_pkg;

    localparam int LEVEL_LOW_DEF  = 0;
    localparam int LEVEL_HIGH_DEF = 15;

    localparam int LVL_W     = 5;
    localparam int TIME_W    = 32;
    localparam int MASK_W    = 16;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CAND_W    = 7;

    typedef logic [LVL_W-1:0]     t_level;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [MASK_W-1:0]    t_mask;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CAND_W-1:0]    t_cand;

    localparam t_mode MODE_REBUILD = 3'd0;
    localparam t_mode MODE_POP     = 3'd1;
    localparam t_mode MODE_FAIL    = 3'd2;
    localparam t_mode MODE_OK      = 3'd3;
    localparam t_mode MODE_CLEAR   = 3'd4;

    localparam t_cfg_idx CFG_RADIUS = 2'd0;
    localparam t_cfg_idx CFG_COOL   = 2'd1;
    localparam t_cfg_idx CFG_SKIP   = 2'd2;

    localparam t_level RADIUS_RST = 5'd15;
    localparam t_time  COOL_RST   = 32'd45000;
    localparam t_level SKIP_RST   = 5'd31;

    typedef struct packed {
        logic clear;
        logic restart;
        logic push;
        logic pop;
    } t_q_cmd;

endpackage

/* sv/pls_in_if.sv */
interface pls_in_if;
    import pls_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode;
    t_level level;
    t_time now_ms;
    t_mask fresh_mask;

    modport source (output valid, output mode, output level, output now_ms,
                    output fresh_mask, input ready);
    modport sink (input valid, input mode, input level, input now_ms,
                  input fresh_mask, output ready);
endinterface

/* sv/pls_out_if.sv */
interface pls_out_if;
    import pls_pkg::*;

    logic   valid;
    logic   ready;
    logic   got_level;
    t_level popped_level;
    t_level queue_count;

    modport source (output valid, output got_level, output popped_level,
                    output queue_count, input ready);
    modport sink (input valid, input got_level, input popped_level,
                  input queue_count, output ready);
endinterface

/* sv/pls_eval_unit.sv */
module pls_eval_unit #(
    parameter int LEVEL_LOW  = pls_pkg::LEVEL_LOW_DEF,
    parameter int LEVEL_HIGH = pls_pkg::LEVEL_HIGH_DEF,
    parameter int QAW        = 4
) (
    input  pls_pkg::t_cand  i_cand,
    input  logic            i_check_skip,
    input  pls_pkg::t_level i_skip,
    input  pls_pkg::t_time  i_now,
    input  pls_pkg::t_mask  i_mask,
    input  pls_pkg::t_time  i_deadline,
    output logic [QAW-1:0]  o_idx,
    output logic            o_ok
);
    import pls_pkg::*;

    logic [5:0]  w_off;
    logic        w_in_range;
    logic        w_fresh;
    logic        w_cooling;
    logic        w_skip_hit;
    t_time       w_diff;

    assign w_in_range = !i_cand[6] && (i_cand[5:0] >= 6'(LEVEL_LOW))
                        && (i_cand[5:0] <= 6'(LEVEL_HIGH));
    assign w_off      = i_cand[5:0] - 6'(LEVEL_LOW);
    assign o_idx      = w_off[QAW-1:0];
    assign w_fresh    = (w_off[5:4] == 2'b00) && i_mask[w_off[3:0]];
    assign w_diff     = i_now - i_deadline;
    assign w_cooling  = w_diff[TIME_W-1];
    assign w_skip_hit = i_check_skip && (i_cand[4:0] == i_skip);
    assign o_ok       = w_in_range && !w_skip_hit && !w_fresh && !w_cooling;

endmodule

/* sv/pls_cool_table.sv */
module pls_cool_table #(
    parameter int LEVEL_LOW  = pls_pkg::LEVEL_LOW_DEF,
    parameter int LEVEL_HIGH = pls_pkg::LEVEL_HIGH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [((LEVEL_HIGH-LEVEL_LOW+1) > 1 ? $clog2(LEVEL_HIGH-LEVEL_LOW+1) : 1)-1:0]
                            i_wr_idx,
    input  pls_pkg::t_time  i_wr_data,
    input  logic [((LEVEL_HIGH-LEVEL_LOW+1) > 1 ? $clog2(LEVEL_HIGH-LEVEL_LOW+1) : 1)-1:0]
                            i_rd_idx,
    output pls_pkg::t_time  o_rd_data
);
    import pls_pkg::*;

    localparam int SPAN = LEVEL_HIGH - LEVEL_LOW + 1;

    t_time r_deadline [SPAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SPAN; i++) begin
                r_deadline[i] <= '0;
            end
        end else if (i_we) begin
            r_deadline[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = (32'(i_rd_idx) < 32'(SPAN)) ? r_deadline[i_rd_idx] : '0;

endmodule

/* sv/pls_level_queue.sv */
module pls_level_queue #(
    parameter int LEVEL_LOW  = pls_pkg::LEVEL_LOW_DEF,
    parameter int LEVEL_HIGH = pls_pkg::LEVEL_HIGH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pls_pkg::t_q_cmd  i_cmd,
    input  pls_pkg::t_level  i_data,
    output pls_pkg::t_level  o_head_level,
    output logic [$clog2(LEVEL_HIGH-LEVEL_LOW+2)-1:0] o_fill
);
    import pls_pkg::*;

    localparam int SPAN = LEVEL_HIGH - LEVEL_LOW + 1;
    localparam int QAW  = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int FW   = $clog2(SPAN + 1);

    t_level         r_mem [SPAN];
    logic [QAW-1:0] r_head;
    logic [FW-1:0]  r_fill;
    logic [QAW-1:0] n_head;
    logic [FW-1:0]  n_fill;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.restart) begin
            n_head = '0;
            n_fill = '0;
        end else if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.push) begin
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.pop) begin
            n_head = (32'(r_head) == SPAN - 1) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.restart && !i_cmd.clear) begin
            r_mem[r_fill[QAW-1:0]] <= i_data;
        end
    end

    assign o_head_level = r_mem[r_head];
    assign o_fill       = r_fill;

endmodule

/* sv/prefetch_level_scheduler_unit.sv */
// Rebuild checks the center, then each distance out to the radius (clamped
//   to span-1) below, then above it; pop drains until an entry is eligible.
// Throughput: one request at a time; one level is checked per cycle by the
//   shared eligibility unit (cooldown subtract, range, fresh and skip test).
// Reset: synchronous, active low; empties the queue, zeroes all cooldown
//   deadlines and loads radius 15, cooldown 45000 ms, skip level 31.
module prefetch_level_scheduler_unit #(
    parameter int LEVEL_LOW  = pls_pkg::LEVEL_LOW_DEF,
    parameter int LEVEL_HIGH = pls_pkg::LEVEL_HIGH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pls_in_if.sink                i_in,
    pls_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  pls_pkg::t_cfg_idx     i_cfg_idx,
    input  pls_pkg::t_cfg_data    i_cfg_data
);
    import pls_pkg::*;

    localparam int SPAN = LEVEL_HIGH - LEVEL_LOW + 1;
    localparam int QAW  = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int FW   = $clog2(SPAN + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    t_level     r_radius, r_skip;
    t_time      r_cool;
    t_level     r_center, n_center;
    t_level     r_dist, n_dist;
    t_level     r_rad, n_rad;
    logic       r_side, n_side;
    t_time      r_now, n_now;
    t_mask      r_mask, n_mask;
    logic       r_got, n_got;
    t_level     r_pop, n_pop;

    logic       r_out_valid;
    logic       r_out_got;
    t_level     r_out_pop;
    t_level     r_out_count;

    t_q_cmd         q_cmd;
    t_level         q_head;
    logic [FW-1:0]  q_fill;

    t_cand          w_cand;
    logic [QAW-1:0] w_idx;
    logic           w_ok;
    t_time          w_deadline;

    logic           w_accept;
    logic           w_load;
    logic           w_cool_we;
    logic [QAW-1:0] w_cool_wr_idx;
    t_time          w_cool_wr_data;
    t_level         w_note_off;
    logic           w_note_in_range;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && (r_state == ST_IDLE);
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign w_note_off      = i_in.level - 5'(LEVEL_LOW);
    assign w_note_in_range = (i_in.level >= 5'(LEVEL_LOW)) && (i_in.level <= 5'(LEVEL_HIGH));
    assign w_cool_wr_idx   = w_note_off[QAW-1:0];

    always_comb begin
        if (r_state == ST_POP) begin
            w_cand = {2'b00, q_head};
        end else if (r_side) begin
            w_cand = {2'b00, r_center} + {2'b00, r_dist};
        end else begin
            w_cand = {2'b00, r_center} - {2'b00, r_dist};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_cool   <= COOL_RST;
            r_skip   <= SKIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[LVL_W-1:0];
                CFG_COOL:   r_cool   <= i_cfg_data[TIME_W-1:0];
                CFG_SKIP:   r_skip   <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        n_center       = r_center;
        n_dist         = r_dist;
        n_rad          = r_rad;
        n_side         = r_side;
        n_now          = r_now;
        n_mask         = r_mask;
        n_got          = r_got;
        n_pop          = r_pop;
        q_cmd          = '0;
        w_cool_we      = 1'b0;
        w_cool_wr_data = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_center = i_in.level;
                    n_now    = i_in.now_ms;
                    n_mask   = i_in.fresh_mask;
                    n_got    = 1'b0;
                    n_pop    = '0;
                    n_dist   = '0;
                    n_side   = 1'b0;
                    n_state  = ST_DONE;
                    case (i_in.mode)
                        MODE_REBUILD: begin
                            q_cmd.restart = 1'b1;
                            n_rad   = (r_radius > 5'(SPAN - 1)) ? 5'(SPAN - 1) : r_radius;
                            n_state = ST_BUILD;
                        end
                        MODE_POP: begin
                            n_state = ST_POP;
                        end
                        MODE_FAIL: begin
                            w_cool_we      = w_note_in_range;
                            w_cool_wr_data = i_in.now_ms + r_cool;
                        end
                        MODE_OK: begin
                            w_cool_we      = w_note_in_range;
                        end
                        MODE_CLEAR: begin
                            q_cmd.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUILD: begin
                q_cmd.push = w_ok && (32'(q_fill) < SPAN);
                if (r_dist == '0) begin
                    if (r_rad == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_dist = 5'd1;
                        n_side = 1'b0;
                    end
                end else if (!r_side) begin
                    n_side = 1'b1;
                end else if (r_dist == r_rad) begin
                    n_state = ST_DONE;
                end else begin
                    n_dist = r_dist + 1'b1;
                    n_side = 1'b0;
                end
            end
            ST_POP: begin
                if (q_fill == '0) begin
                    n_state = ST_DONE;
                end else begin
                    q_cmd.pop = 1'b1;
                    if (w_ok) begin
                        n_got   = 1'b1;
                        n_pop   = q_head;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we && (i_cfg_idx == CFG_RADIUS)) begin
            q_cmd.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_center <= n_center;
        r_dist   <= n_dist;
        r_rad    <= n_rad;
        r_side   <= n_side;
        r_now    <= n_now;
        r_mask   <= n_mask;
        r_got    <= n_got;
        r_pop    <= n_pop;
        if (w_load) begin
            r_out_got   <= r_got;
            r_out_pop   <= r_pop;
            r_out_count <= 5'(q_fill);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.got_level    = r_out_got;
    assign o_out.popped_level = r_out_pop;
    assign o_out.queue_count  = r_out_count;

    pls_eval_unit #(
        .LEVEL_LOW  (LEVEL_LOW),
        .LEVEL_HIGH (LEVEL_HIGH),
        .QAW        (QAW)
    ) u_eval (
        .i_cand       (w_cand),
        .i_check_skip (r_state == ST_BUILD),
        .i_skip       (r_skip),
        .i_now        (r_now),
        .i_mask       (r_mask),
        .i_deadline   (w_deadline),
        .o_idx        (w_idx),
        .o_ok         (w_ok)
    );

    pls_cool_table #(
        .LEVEL_LOW  (LEVEL_LOW),
        .LEVEL_HIGH (LEVEL_HIGH)
    ) u_cool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_cool_we),
        .i_wr_idx  (w_cool_wr_idx),
        .i_wr_data (w_cool_wr_data),
        .i_rd_idx  (w_idx),
        .o_rd_data (w_deadline)
    );

    pls_level_queue #(
        .LEVEL_LOW  (LEVEL_LOW),
        .LEVEL_HIGH (LEVEL_HIGH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_cmd),
        .i_data       (w_cand[LVL_W-1:0]),
        .o_head_level (q_head),
        .o_fill       (q_fill)
    );

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_fill) <= SPAN)
        else $error("queue fill beyond span");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("request accepted without leaving idle");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) && (q_fill != '0) && !i_cfg_we
        |=> (q_fill == $past(q_fill) - 1'b1))
        else $error("pop did not drop one entry");

    a_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_got |-> (r_out_pop == '0))
        else $error("popped level set without a level");
`endif

endmodule
